// ===== design/ookpwd_pkg.sv =====
`timescale 1ns / 1ps

package ookpwd_pkg;

   localparam int DUR_W     = 20;
   localparam int CODE_W    = 32;
   localparam int CNT_W     = 6;
   localparam int UNIT_W    = 16;
   localparam int SUM_W     = 27;
   localparam int OUT_W     = 20;
   localparam int NEAR_W    = 22;
   localparam int DEN_W     = 21;
   localparam int GNUM_W    = 22;
   localparam int DIV_CNT_W = 5;
   localparam int CSR_IDX_W = 4;

   typedef logic [NEAR_W-1:0]    near_type;
   typedef logic [SUM_W-1:0]     sum_type;
   typedef logic [SUM_W:0]       sum_wide_type;
   typedef logic [DUR_W-1:0]     dur_type;
   typedef logic [DEN_W-1:0]     den_type;
   typedef logic [GNUM_W-1:0]    gnum_type;
   typedef logic [DIV_CNT_W-1:0] div_cnt_type;

   localparam div_cnt_type UNIT_STEPS  = div_cnt_type'(SUM_W);
   localparam div_cnt_type GUARD_STEPS = div_cnt_type'(GNUM_W);
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [UNIT_W-1:0] SHORT_RESET = 16'd390;
   localparam logic [UNIT_W-1:0] LONG_RESET  = 16'd1170;
   localparam logic [UNIT_W-1:0] TOL_RESET   = 16'd300;
   localparam logic [CNT_W-1:0]  FRAME_RESET = 6'd24;

   typedef enum logic [1:0] {
      PH_SYNC = 2'd0,
      PH_HIGH = 2'd1,
      PH_LOW  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_UNIT,
      ST_UNIT_DONE,
      ST_DIV_GUARD,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHORT_UNIT = 4'd0,
      CSR_LONG_UNIT  = 4'd1,
      CSR_TOLERANCE  = 4'd2,
      CSR_FRAME_BITS = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic req_ready;
      logic unit_start;
      logic div_step;
      logic unit_load;
      logic guard_start;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic emit;
      logic div_last;
      logic unit_zero;
      logic out_free;
   } dp_status_type;

   function automatic logic near_f(input near_type x, input near_type y, input near_type d);
      near_type diff;
      diff = (x > y) ? (x - y) : (y - x);
      return diff < d;
   endfunction

endpackage

// ===== design/ookpwd_ifs.sv =====
`timescale 1ns / 1ps

interface ookpwd_req_if;
   logic                            valid;
   logic                            ready;
   logic [ookpwd_pkg::DUR_W-1:0]    pulse_duration;
   logic                            pulse_level;
   modport source (output valid, output pulse_duration, output pulse_level, input ready);
   modport sink   (input valid, input pulse_duration, input pulse_level, output ready);
endinterface

interface ookpwd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ookpwd_pkg::CODE_W-1:0]   code;
   logic [ookpwd_pkg::CNT_W-1:0]    code_bits;
   logic [ookpwd_pkg::OUT_W-1:0]    unit_time;
   logic [ookpwd_pkg::OUT_W-1:0]    guard_ratio;
   modport source (output valid, output code, output code_bits, output unit_time,
                   output guard_ratio, input ready);
   modport sink   (input valid, input code, input code_bits, input unit_time,
                   input guard_ratio, output ready);
endinterface

interface ookpwd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ookpwd_pkg::CSR_IDX_W-1:0] index;
   logic [ookpwd_pkg::UNIT_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/ookpwd_ctrl.sv =====
`timescale 1ns / 1ps

module ookpwd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  ookpwd_pkg::dp_status_type status,
   output ookpwd_pkg::ctrl_cmd_type  cmd
);

   ookpwd_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ookpwd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ookpwd_pkg::ST_IDLE: begin
            if (status.req_valid && status.emit) state_in = ookpwd_pkg::ST_DIV_UNIT;
         end
         ookpwd_pkg::ST_DIV_UNIT: begin
            if (status.div_last) state_in = ookpwd_pkg::ST_UNIT_DONE;
         end
         ookpwd_pkg::ST_UNIT_DONE: begin
            state_in = status.unit_zero ? ookpwd_pkg::ST_EMIT : ookpwd_pkg::ST_DIV_GUARD;
         end
         ookpwd_pkg::ST_DIV_GUARD: begin
            if (status.div_last) state_in = ookpwd_pkg::ST_EMIT;
         end
         ookpwd_pkg::ST_EMIT: begin
            if (status.out_free) state_in = ookpwd_pkg::ST_IDLE;
         end
         default: begin
            state_in = ookpwd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ookpwd_pkg::ST_IDLE: begin
            cmd.req_ready  = 1'b1;
            cmd.unit_start = status.req_valid && status.emit;
         end
         ookpwd_pkg::ST_DIV_UNIT: begin
            cmd.div_step = 1'b1;
         end
         ookpwd_pkg::ST_UNIT_DONE: begin
            cmd.unit_load   = 1'b1;
            cmd.guard_start = !status.unit_zero;
         end
         ookpwd_pkg::ST_DIV_GUARD: begin
            cmd.div_step = 1'b1;
         end
         ookpwd_pkg::ST_EMIT: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_start_divides: assert property (@(posedge clock) disable iff (reset)
      cmd.unit_start |=> state_ff == ookpwd_pkg::ST_DIV_UNIT)
      else $error("frame end did not start the unit division");

   a_guard_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ookpwd_pkg::ST_DIV_GUARD && status.div_last) |=>
      state_ff == ookpwd_pkg::ST_EMIT)
      else $error("guard division did not finish into emit");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded over a pending transfer");

   a_no_zero_div: assert property (@(posedge clock) disable iff (reset)
      cmd.guard_start |-> !status.unit_zero)
      else $error("guard division started with zero unit time");
`endif

endmodule

// ===== design/ookpwd_dp.sv =====
`timescale 1ns / 1ps

module ookpwd_dp (
   input  logic                      clock,
   input  logic                      reset,
   ookpwd_req_if.sink                req_chan,
   ookpwd_rsp_if.source              rsp_chan,
   ookpwd_csr_if.sink                csr_chan,
   input  ookpwd_pkg::ctrl_cmd_type  cmd,
   output ookpwd_pkg::dp_status_type status
);

   logic [ookpwd_pkg::UNIT_W-1:0] short_ff, long_ff, tol_ff;
   logic [ookpwd_pkg::CNT_W-1:0]  frame_ff;

   ookpwd_pkg::phase_type            phase_ff, phase_in;
   logic [ookpwd_pkg::CODE_W-1:0]    shift_ff, shift_in;
   logic [ookpwd_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   ookpwd_pkg::dur_type              prior_ff, prior_in;
   ookpwd_pkg::sum_type              sum_ff, sum_in;
   logic [ookpwd_pkg::CODE_W-1:0]    prev_ff, prev_in;

   logic [ookpwd_pkg::CODE_W-1:0]    res_code_ff;
   logic [ookpwd_pkg::CNT_W-1:0]     res_bits_ff;
   ookpwd_pkg::dur_type              gap_ff;
   logic [ookpwd_pkg::OUT_W-1:0]     unit_ff;

   ookpwd_pkg::den_type              rem_ff, den_ff;
   ookpwd_pkg::sum_type              quo_ff;
   ookpwd_pkg::div_cnt_type          dcnt_ff;

   logic                             rsp_valid_ff;
   logic [ookpwd_pkg::CODE_W-1:0]    out_code_ff;
   logic [ookpwd_pkg::CNT_W-1:0]     out_bits_ff;
   logic [ookpwd_pkg::OUT_W-1:0]     out_unit_ff, out_guard_ff;

   logic                             accept;
   ookpwd_pkg::dur_type              dur;
   logic                             hi;
   ookpwd_pkg::sum_wide_type         sum_add;
   ookpwd_pkg::sum_type              sum_sat;
   ookpwd_pkg::near_type             tol3, tol36, short36;
   logic                             end_gap, cnt_match, is_bit0, is_bit1, emit;
   logic [ookpwd_pkg::CNT_W-1:0]     cnt_inc;

   logic [ookpwd_pkg::DEN_W:0]       trial, trial_diff;
   logic                             fits;
   logic [ookpwd_pkg::OUT_W-1:0]     unit_sat, guard_sat;
   ookpwd_pkg::gnum_type             gnum;

   assign accept         = cmd.req_ready && req_chan.valid;
   assign req_chan.ready = cmd.req_ready;
   assign csr_chan.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff <= ookpwd_pkg::SHORT_RESET;
         long_ff  <= ookpwd_pkg::LONG_RESET;
         tol_ff   <= ookpwd_pkg::TOL_RESET;
         frame_ff <= ookpwd_pkg::FRAME_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            ookpwd_pkg::CSR_SHORT_UNIT: short_ff <= csr_chan.data;
            ookpwd_pkg::CSR_LONG_UNIT:  long_ff  <= csr_chan.data;
            ookpwd_pkg::CSR_TOLERANCE:  tol_ff   <= csr_chan.data;
            ookpwd_pkg::CSR_FRAME_BITS: frame_ff <= csr_chan.data[ookpwd_pkg::CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // pulse classification and frame state
   always_comb begin
      dur       = req_chan.pulse_duration;
      hi        = req_chan.pulse_level;
      sum_add   = ookpwd_pkg::sum_wide_type'(sum_ff) + ookpwd_pkg::sum_wide_type'(dur);
      sum_sat   = sum_add[ookpwd_pkg::SUM_W] ? '1 : sum_add[ookpwd_pkg::SUM_W-1:0];
      tol3      = ookpwd_pkg::near_type'({tol_ff, 1'b0}) + ookpwd_pkg::near_type'(tol_ff);
      tol36     = ookpwd_pkg::near_type'({tol_ff, 5'b0}) + ookpwd_pkg::near_type'({tol_ff, 2'b0});
      short36   = ookpwd_pkg::near_type'({short_ff, 5'b0})
                + ookpwd_pkg::near_type'({short_ff, 2'b0});
      end_gap   = dur >= ookpwd_pkg::dur_type'({long_ff, 1'b0});
      cnt_match = cnt_ff == frame_ff;
      is_bit0   = ookpwd_pkg::near_f(ookpwd_pkg::near_type'(prior_ff),
                     ookpwd_pkg::near_type'(short_ff), ookpwd_pkg::near_type'(tol_ff))
               && ookpwd_pkg::near_f(ookpwd_pkg::near_type'(dur),
                     ookpwd_pkg::near_type'(long_ff), tol3);
      is_bit1   = ookpwd_pkg::near_f(ookpwd_pkg::near_type'(prior_ff),
                     ookpwd_pkg::near_type'(long_ff), tol3)
               && ookpwd_pkg::near_f(ookpwd_pkg::near_type'(dur),
                     ookpwd_pkg::near_type'(short_ff), ookpwd_pkg::near_type'(tol_ff));
      cnt_inc   = (cnt_ff == ookpwd_pkg::CNT_MAX) ? cnt_ff : cnt_ff + 1'b1;

      phase_in = phase_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      prior_in = prior_ff;
      sum_in   = sum_ff;
      prev_in  = prev_ff;
      emit     = 1'b0;

      unique case (phase_ff)
         ookpwd_pkg::PH_HIGH: begin
            if (hi) begin
               prior_in = dur;
               sum_in   = sum_sat;
               phase_in = ookpwd_pkg::PH_LOW;
            end
         end
         ookpwd_pkg::PH_LOW: begin
            if (hi) begin
               phase_in = ookpwd_pkg::PH_SYNC;
            end else if (end_gap) begin
               phase_in = ookpwd_pkg::PH_HIGH;
               if (cnt_match) begin
                  emit    = (prev_ff == shift_ff) && (prev_ff != '0);
                  prev_in = shift_ff;
               end
               shift_in = '0;
               cnt_in   = '0;
               sum_in   = '0;
            end else begin
               sum_in = sum_sat;
               if (is_bit0 || is_bit1) begin
                  shift_in = {shift_ff[ookpwd_pkg::CODE_W-2:0], is_bit1 && !is_bit0};
                  cnt_in   = cnt_inc;
                  phase_in = ookpwd_pkg::PH_HIGH;
               end else begin
                  phase_in = ookpwd_pkg::PH_SYNC;
               end
            end
         end
         default: begin
            if (!hi && ookpwd_pkg::near_f(ookpwd_pkg::near_type'(dur), short36, tol36)) begin
               phase_in = ookpwd_pkg::PH_HIGH;
               shift_in = '0;
               cnt_in   = '0;
               prior_in = '0;
               sum_in   = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ookpwd_pkg::PH_SYNC;
         shift_ff <= '0;
         cnt_ff   <= '0;
         prior_ff <= '0;
         sum_ff   <= '0;
         prev_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         cnt_ff   <= cnt_in;
         prior_ff <= prior_in;
         sum_ff   <= sum_in;
         prev_ff  <= prev_in;
      end
   end

   // shared restoring divider, one quotient bit per cycle
   always_comb begin
      trial      = {rem_ff, quo_ff[ookpwd_pkg::SUM_W-1]};
      trial_diff = trial - {1'b0, den_ff};
      fits       = trial >= {1'b0, den_ff};
      unit_sat   = (|quo_ff[ookpwd_pkg::SUM_W-1:ookpwd_pkg::OUT_W]) ? '1
                 : quo_ff[ookpwd_pkg::OUT_W-1:0];
      gnum       = ookpwd_pkg::gnum_type'({gap_ff, 1'b0}) + ookpwd_pkg::gnum_type'(unit_sat);
      if (unit_ff == '0) begin
         guard_sat = '1;
      end else begin
         guard_sat = (|quo_ff[ookpwd_pkg::GNUM_W-1:ookpwd_pkg::OUT_W]) ? '1
                   : quo_ff[ookpwd_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.unit_start) begin
         res_code_ff <= shift_ff;
         res_bits_ff <= cnt_ff;
         gap_ff      <= dur;
         rem_ff      <= '0;
         quo_ff      <= sum_ff;
         den_ff      <= ookpwd_pkg::den_type'({cnt_ff, 2'b01});
         dcnt_ff     <= ookpwd_pkg::UNIT_STEPS;
      end else if (cmd.guard_start) begin
         rem_ff  <= '0;
         quo_ff  <= ookpwd_pkg::sum_type'(gnum) << (ookpwd_pkg::SUM_W - ookpwd_pkg::GNUM_W);
         den_ff  <= ookpwd_pkg::den_type'({unit_sat, 1'b0});
         dcnt_ff <= ookpwd_pkg::GUARD_STEPS;
      end else if (cmd.div_step) begin
         rem_ff  <= fits ? trial_diff[ookpwd_pkg::DEN_W-1:0] : trial[ookpwd_pkg::DEN_W-1:0];
         quo_ff  <= {quo_ff[ookpwd_pkg::SUM_W-2:0], fits};
         dcnt_ff <= dcnt_ff - 1'b1;
      end
      if (cmd.unit_load) begin
         unit_ff <= unit_sat;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_code_ff  <= res_code_ff;
         out_bits_ff  <= res_bits_ff;
         out_unit_ff  <= unit_ff;
         out_guard_ff <= guard_sat;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.code        = out_code_ff;
   assign rsp_chan.code_bits   = out_bits_ff;
   assign rsp_chan.unit_time   = out_unit_ff;
   assign rsp_chan.guard_ratio = out_guard_ff;

   always_comb begin
      status.req_valid = req_chan.valid;
      status.emit      = emit;
      status.div_last  = dcnt_ff == ookpwd_pkg::div_cnt_type'(1);
      status.unit_zero = unit_sat == '0;
      status.out_free  = !rsp_valid_ff || rsp_chan.ready;
   end

endmodule

// ===== design/ook_pulse_width_code_decoder_unit.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// req_chan  in   valid/ready    pulse_duration[19:0], pulse_level
// rsp_chan  out  valid/ready    code[31:0], code_bits[5:0], unit_time[19:0], guard_ratio[19:0]
// csr_chan  in   valid/ready    index[3:0], data[15:0]; ready always high
//
// Pulses are accepted while idle; a pulse that completes a matching repeat frame
// stalls the request channel through the 27-step and 22-step passes (no guard
// pass with zero unit time) of one shared restoring divider. Synchronous active-high
// reset restores the register defaults and sync search. A finished result waits in
// the output register while pulses keep flowing; a second result holds until it is taken.

module ook_pulse_width_code_decoder_unit (
   input  logic         clock,
   input  logic         reset,
   ookpwd_req_if.sink   req_chan,
   ookpwd_rsp_if.source rsp_chan,
   ookpwd_csr_if.sink   csr_chan
);

   ookpwd_pkg::ctrl_cmd_type  cmd;
   ookpwd_pkg::dp_status_type status;

   ookpwd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   ookpwd_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .status   (status)
   );

endmodule
